[hw/rtl/integer_to_roman_numeral_assert.svh]
// ---------------------------------------------------------------------------
// Roman numeral converter assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH

`ifndef SYNTHESIS
`define ITRN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itrn assertion failed");
`define ITRN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itrn assertion failed");
`else
`define ITRN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ITRN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/itrn_pkg.sv]
// ---------------------------------------------------------------------------
// Roman numeral converter package
// Letter codes, microcode word layout and datapath control types.
// ---------------------------------------------------------------------------
package itrn_pkg;

    localparam int VAL_W    = 12;
    localparam int LET_W    = 7;
    localparam int STEP_W   = 4;

    localparam logic [VAL_W-1:0] MAX_VALUE = 12'd3999;

    localparam logic [LET_W-1:0] CH_NONE = 7'h00;
    localparam logic [LET_W-1:0] CH_I    = 7'h49;
    localparam logic [LET_W-1:0] CH_V    = 7'h56;
    localparam logic [LET_W-1:0] CH_X    = 7'h58;
    localparam logic [LET_W-1:0] CH_L    = 7'h4C;
    localparam logic [LET_W-1:0] CH_C    = 7'h43;
    localparam logic [LET_W-1:0] CH_D    = 7'h44;
    localparam logic [LET_W-1:0] CH_M    = 7'h4D;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [LET_W-1:0] let_a;
        logic [LET_W-1:0] let_b;
        logic             pair;
        logic             rep;
    } ucw_t;

    typedef struct packed {
        logic             load;
        logic             sub;
        logic             emit;
        logic [LET_W-1:0] letter;
        logic             last;
        logic             empty_res;
        logic             too_large;
    } dp_ctl_t;

    typedef struct packed {
        logic ge;
        logic eq;
        logic in_zero;
        logic in_big;
    } dp_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PAIR
    } seq_state_t;

endpackage

[hw/rtl/itrn_ucode_rom.sv]
// ---------------------------------------------------------------------------
// Roman numeral converter microcode ROM
// One control word per step: weight, letters, pair and repeat flags.
// ---------------------------------------------------------------------------
module itrn_ucode_rom (
    input  logic [itrn_pkg::STEP_W-1:0] step,
    output itrn_pkg::ucw_t              cw
);

    always_comb
    begin
        unique case (step)
            4'd0:    cw = '{12'd1000, itrn_pkg::CH_M, itrn_pkg::CH_NONE, 1'b0, 1'b1};
            4'd1:    cw = '{12'd900,  itrn_pkg::CH_C, itrn_pkg::CH_M,    1'b1, 1'b0};
            4'd2:    cw = '{12'd500,  itrn_pkg::CH_D, itrn_pkg::CH_NONE, 1'b0, 1'b0};
            4'd3:    cw = '{12'd400,  itrn_pkg::CH_C, itrn_pkg::CH_D,    1'b1, 1'b0};
            4'd4:    cw = '{12'd100,  itrn_pkg::CH_C, itrn_pkg::CH_NONE, 1'b0, 1'b1};
            4'd5:    cw = '{12'd90,   itrn_pkg::CH_X, itrn_pkg::CH_C,    1'b1, 1'b0};
            4'd6:    cw = '{12'd50,   itrn_pkg::CH_L, itrn_pkg::CH_NONE, 1'b0, 1'b0};
            4'd7:    cw = '{12'd40,   itrn_pkg::CH_X, itrn_pkg::CH_L,    1'b1, 1'b0};
            4'd8:    cw = '{12'd10,   itrn_pkg::CH_X, itrn_pkg::CH_NONE, 1'b0, 1'b1};
            4'd9:    cw = '{12'd9,    itrn_pkg::CH_I, itrn_pkg::CH_X,    1'b1, 1'b0};
            4'd10:   cw = '{12'd5,    itrn_pkg::CH_V, itrn_pkg::CH_NONE, 1'b0, 1'b0};
            4'd11:   cw = '{12'd4,    itrn_pkg::CH_I, itrn_pkg::CH_V,    1'b1, 1'b0};
            default: cw = '{12'd1,    itrn_pkg::CH_I, itrn_pkg::CH_NONE, 1'b0, 1'b1};
        endcase
    end

endmodule

[hw/rtl/itrn_dp.sv]
// ---------------------------------------------------------------------------
// Roman numeral converter datapath
// Remainder register, weight compare and subtract, registered word output.
// ---------------------------------------------------------------------------
module itrn_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [itrn_pkg::VAL_W-1:0] value,
    input  logic [itrn_pkg::VAL_W-1:0] weight,
    input  itrn_pkg::dp_ctl_t          ctl,
    output itrn_pkg::dp_stat_t         stat,
    output logic                       strobe,
    output logic [itrn_pkg::LET_W-1:0] letter,
    output logic                       last,
    output logic                       empty_res,
    output logic                       too_large
);

    logic [itrn_pkg::VAL_W-1:0] rem_reg;
    logic [itrn_pkg::VAL_W-1:0] rem_next;
    logic                       strobe_reg;
    logic [itrn_pkg::LET_W-1:0] letter_reg;
    logic                       last_reg;
    logic                       empty_reg;
    logic                       large_reg;

    always_comb
    begin
        stat.ge      = (rem_reg >= weight);
        stat.eq      = (rem_reg == weight);
        stat.in_zero = (value == '0);
        stat.in_big  = (value > itrn_pkg::MAX_VALUE);
    end

    always_comb
    begin
        priority if (ctl.load)
            rem_next = value;
        else if (ctl.sub)
            rem_next = rem_reg - weight;
        else
            rem_next = rem_reg;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (ctl.emit)
        begin
            letter_reg <= ctl.letter;
            last_reg   <= ctl.last;
            empty_reg  <= ctl.empty_res;
            large_reg  <= ctl.too_large;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= ctl.emit;
    end

    assign strobe    = strobe_reg;
    assign letter    = letter_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;
    assign too_large = large_reg;

endmodule

[hw/rtl/integer_to_roman_numeral.sv]
// ---------------------------------------------------------------------------
// Integer to Roman numeral converter
// Microcoded weight-table sequencer: one letter word per cycle, none on a skip.
// ---------------------------------------------------------------------------
// A flag word is strobed in the cycle after start is taken; the first letter
// word is emitted from ST_RUN after any table steps skipped before it.
// Zero or above 3999: one flag word, busy never rises, next start next cycle.
// Otherwise busy is high while the sequencer runs through letters and skips.
// Reset (rst_n low, async) returns the sequencer to idle and drops strobe.
// The receiver cannot stall; each word is on the ports for one cycle.
module integer_to_roman_numeral (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [itrn_pkg::VAL_W-1:0] value,
    output logic                       strobe,
    output logic [itrn_pkg::LET_W-1:0] letter,
    output logic                       last,
    output logic                       empty_res,
    output logic                       too_large
);

`include "integer_to_roman_numeral_assert.svh"

    itrn_pkg::seq_state_t        state_reg;
    itrn_pkg::seq_state_t        state_next;
    logic [itrn_pkg::STEP_W-1:0] step_reg;
    logic [itrn_pkg::STEP_W-1:0] step_next;
    itrn_pkg::ucw_t              cw;
    itrn_pkg::dp_ctl_t           ctl;
    itrn_pkg::dp_stat_t          stat;

    itrn_ucode_rom u_rom (
        .step (step_reg),
        .cw   (cw)
    );

    itrn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .weight    (cw.val),
        .ctl       (ctl),
        .stat      (stat),
        .strobe    (strobe),
        .letter    (letter),
        .last      (last),
        .empty_res (empty_res),
        .too_large (too_large)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            itrn_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (start && !stat.in_zero && !stat.in_big)
                    state_next = itrn_pkg::ST_RUN;
            end
            itrn_pkg::ST_RUN:
            begin
                priority if (!stat.ge)
                    step_next = step_reg + 4'd1;
                else if (cw.pair)
                    state_next = itrn_pkg::ST_PAIR;
                else if (stat.eq)
                    state_next = itrn_pkg::ST_IDLE;
                else if (!cw.rep)
                    step_next = step_reg + 4'd1;
            end
            itrn_pkg::ST_PAIR:
            begin
                step_next  = step_reg + 4'd1;
                state_next = stat.eq ? itrn_pkg::ST_IDLE : itrn_pkg::ST_RUN;
            end
            default:
            begin
                state_next = itrn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.letter    = itrn_pkg::CH_NONE;
        busy          = (state_reg != itrn_pkg::ST_IDLE);
        unique case (state_reg)
            itrn_pkg::ST_IDLE:
            begin
                ctl.load = start;
                if (start && (stat.in_zero || stat.in_big))
                begin
                    ctl.emit      = 1'b1;
                    ctl.last      = 1'b1;
                    ctl.empty_res = stat.in_zero;
                    ctl.too_large = stat.in_big;
                end
            end
            itrn_pkg::ST_RUN:
            begin
                if (stat.ge)
                begin
                    ctl.emit   = 1'b1;
                    ctl.letter = cw.let_a;
                    ctl.sub    = !cw.pair;
                    ctl.last   = !cw.pair && stat.eq;
                end
            end
            itrn_pkg::ST_PAIR:
            begin
                ctl.emit   = 1'b1;
                ctl.letter = cw.let_b;
                ctl.sub    = 1'b1;
                ctl.last   = stat.eq;
            end
            default:
            begin
                ctl.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itrn_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `ITRN_ASSERT_IMP(a_flag_is_last, clk, rst_n, strobe && (empty_res || too_large), last)
    `ITRN_ASSERT_IMP(a_flags_exclusive, clk, rst_n, strobe, !(empty_res && too_large))
    `ITRN_ASSERT_NEXT(a_pair_emits, clk, rst_n, state_reg == itrn_pkg::ST_PAIR, strobe && !empty_res)
    `ITRN_ASSERT_NEXT(a_zero_flag, clk, rst_n, start && !busy && value == '0, strobe && empty_res && last)
    `ITRN_ASSERT_NEXT(a_last_ends_run, clk, rst_n, busy && ctl.emit && ctl.last, !busy)

endmodule
